/* rtl/log_distance_path_loss_macros.svh */
// Assertion macros for the checker file of the path loss block.
// Each macro names the clock clk and the active-low reset rst_n of the
// module that uses it.
`ifndef LOG_DISTANCE_PATH_LOSS_MACROS_SVH
`define LOG_DISTANCE_PATH_LOSS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LDPL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("log distance path loss: check failed");

// The consequent must hold in the cycle after the antecedent.
`define LDPL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("log distance path loss: check failed");

`endif

/* rtl/ldpl_pkg.sv */
`default_nettype none

package ldpl_pkg;

  // Configuration port.
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATH_EXPONENT      = 2'd0,
    REG_REFERENCE_DISTANCE = 2'd1,
    REG_REFERENCE_LOSS     = 2'd2
  } cfg_reg_t;

  // Register reset values and values derived from them.
  localparam logic [10:0] PATH_EXPONENT_RST      = 11'd768;
  localparam logic [15:0] REFERENCE_DISTANCE_RST = 16'd16;
  localparam logic [15:0] REFERENCE_LOSS_RST     = 16'd11949;
  localparam logic [31:0] D0SQ_RST               = 32'd256;
  localparam logic [31:0] COEF_RST               = 32'd1212107520;

  // Result channel layout.
  localparam int ATTEN_W       = 18;
  localparam int OUT_TDATA_W   = 24;
  localparam int OUT_TUSER_W   = 2;
  localparam int USER_NEAR_BIT = 0;
  localparam int USER_SAT_BIT  = 1;
  localparam logic [ATTEN_W-1:0] ATTEN_FLOOR = 18'h20000;
  localparam int ATTEN_LIMIT   = 131072;

  // Arithmetic constants.
  localparam int LOG_FRAC_BITS = 16;
  // Five times log10(2) in Q20.
  localparam logic [20:0] LOSS_SCALE = 21'd1578265;
  localparam int ROUND_SHIFT = 36;

  typedef logic [LOG_FRAC_BITS-1:0] log_frac_t;

  // Fraction bits of log2 of a Q30 value in [1, 2), by repeated squaring.
  function automatic log_frac_t log2_frac(input logic [63:0] x0);
    logic [63:0] x;
    log_frac_t   frac;
    x    = x0;
    frac = '0;
    for (int b = 0; b < LOG_FRAC_BITS; b++) begin
      x    = (x * x) >> 30;
      frac = {frac[LOG_FRAC_BITS-2:0], 1'b0};
      if (x >= 64'h0000_0000_8000_0000) begin
        x       = x >> 1;
        frac[0] = 1'b1;
      end
    end
    return frac;
  endfunction

endpackage

`default_nettype wire

/* rtl/log_distance_path_loss.sv */
`default_nettype none

// Log-distance path loss. Each request carries two node positions in 1/16 m
// and yields one attenuation in 1/256 dB with a near-field and a saturation
// flag. The block is an eleven-stage pipeline: one request is taken every
// cycle while the result side does not stall. Each stage holds its request
// while the stage after it is full and stalled, so empty stages still fill
// and nothing is lost or repeated. The log2 fraction table of LOG_TABLE_DEPTH
// entries is a constant ROM built at elaboration and read twice per request
// in one registered stage. Configuration writes are taken in every cycle and
// must only be made while no request is in flight.
module log_distance_path_loss #(
  parameter int COORD_BITS      = 20,
  parameter int LOG_TABLE_DEPTH = 256,
  localparam int IN_TDATA_W     = ((6 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Configuration write channel.
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ldpl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [ldpl_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Request channel.
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // Fields from bit 0: first_x, first_y, first_z, second_x, second_y, second_z.
  input  wire logic [IN_TDATA_W-1:0]              in_tdata,
  // Result channel.
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // Fields from bit 0: attenuation, then zero padding.
  output logic [ldpl_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // Fields from bit 0: near_field, saturated.
  output logic [ldpl_pkg::OUT_TUSER_W-1:0]        out_tuser
);

  import ldpl_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int MAGW  = CW + 1;
  localparam int SQW   = 2 * CW + 1;
  localparam int D2W   = 2 * CW + 2;
  localparam int LW    = ((D2W > 32) ? D2W : 32) + 1;
  localparam int PW    = $clog2(LW);
  localparam int IW    = $clog2(LOG_TABLE_DEPTH);
  localparam int MW    = 32 + IW;
  localparam int LAW   = PW + LOG_FRAC_BITS;
  localparam int PRW   = LAW + 32;
  localparam int LOSSW = PRW + 1 - ROUND_SHIFT;
  localparam int TOTW  = LOSSW + 1;
  localparam int NST   = 11;

  localparam logic [MW-1:0]    DEPTH_M = MW'(LOG_TABLE_DEPTH);
  localparam logic [PRW:0]     ROUND_HALF = (PRW + 1)'(1) << (ROUND_SHIFT - 1);
  localparam logic [PW-1:0]    TOP_POS = PW'(LW - 1);
  localparam logic [TOTW-1:0]  LIMIT_T = TOTW'(ATTEN_LIMIT);

  // Constant log2 fraction table.
  log_frac_t log_rom [LOG_TABLE_DEPTH];

  for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [63:0] X0 =
      64'(((64'(LOG_TABLE_DEPTH) + 64'(gi)) << 30) / LOG_TABLE_DEPTH);
    localparam log_frac_t FRAC = log2_frac(X0);
    assign log_rom[gi] = FRAC;
  end

  // Position of the leading one of a nonzero word.
  function automatic logic [PW-1:0] lead_one(input logic [LW-1:0] v);
    logic [PW-1:0] k;
    k = '0;
    for (int i = 0; i < LW; i++) begin
      if (v[i]) begin
        k = PW'(i);
      end
    end
    return k;
  endfunction

  // Configuration registers and the values derived from them.
  logic [10:0] pe_r;
  logic [15:0] rd_r;
  logic [15:0] rl_r;
  logic [31:0] d0sq_r;
  logic [31:0] coef_r;
  logic [15:0] d0;

  assign cfg_ready = 1'b1;
  assign d0 = (rd_r == 16'd0) ? 16'd1 : rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pe_r <= PATH_EXPONENT_RST;
      rd_r <= REFERENCE_DISTANCE_RST;
      rl_r <= REFERENCE_LOSS_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATH_EXPONENT:      pe_r <= cfg_data[10:0];
        REG_REFERENCE_DISTANCE: rd_r <= cfg_data;
        REG_REFERENCE_LOSS:     rl_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Squared reference distance and loss coefficient follow the registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0sq_r <= D0SQ_RST;
      coef_r <= COEF_RST;
    end else begin
      d0sq_r <= 32'(d0) * 32'(d0);
      coef_r <= 32'(pe_r) * 32'(LOSS_SCALE);
    end
  end

  // Stage occupancy and load enables: a stage loads when it is empty or
  // the stage after it moves on.
  logic [NST-1:0] vld_r;
  logic [NST-1:0] ce;

  always_comb begin
    ce[NST-1] = !vld_r[NST-1] || out_tready;
    for (int s = NST - 2; s >= 0; s--) begin
      ce[s] = !vld_r[s] || ce[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ce[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int s = 1; s < NST; s++) begin
        if (ce[s]) begin
          vld_r[s] <= vld_r[s-1];
        end
      end
    end
  end

  assign in_tready = ce[0];

  // Per-axis absolute differences.
  logic [MAGW-1:0] diff [3];
  logic [MAGW-1:0] mag_nxt [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = {in_tdata[a*CW + CW - 1], in_tdata[a*CW +: CW]} -
                {in_tdata[(a+3)*CW + CW - 1], in_tdata[(a+3)*CW +: CW]};
      mag_nxt[a] = diff[a][MAGW-1] ? (~diff[a] + MAGW'(1)) : diff[a];
    end
  end

  // Stage logic between registers.
  logic          near_nxt;
  logic [PW-1:0] ka_nxt;
  logic [PW-1:0] kb_nxt;
  logic [LW-1:0] ma;
  logic [LW-1:0] mb;
  logic [MW-1:0] proda;
  logic [MW-1:0] prodb;
  logic [LAW-1:0] la;
  logic [LAW-1:0] lb;
  logic [PRW:0]   rnd;
  logic [TOTW-1:0] total;
  logic [TOTW-1:0] neg;

  // Pipeline payload registers.
  logic [MAGW-1:0]  mag_r [3];
  logic [SQW-1:0]   sq_r [3];
  logic [LW-1:0]    d2_r;
  logic [LW-1:0]    d2s3_r;
  logic [PW-1:0]    ka3_r, kb3_r, ka4_r, kb4_r, ka5_r, kb5_r, ka6_r, kb6_r;
  logic [31:0]      fa4_r, fb4_r;
  logic [IW-1:0]    ia5_r, ib5_r;
  log_frac_t        ta6_r, tb6_r;
  logic [LAW-1:0]   l7_r;
  logic [PRW-1:0]   p8_r;
  logic [LOSSW-1:0] loss9_r;
  logic [NST-1:3]   near_r;
  logic [ATTEN_W-1:0] atten_r;
  logic             sat_r;

  always_comb begin
    near_nxt = (d2_r <= LW'(d0sq_r));
    ka_nxt   = lead_one(d2_r);
    kb_nxt   = lead_one(LW'(d0sq_r));
    ma       = d2s3_r << (TOP_POS - ka3_r);
    mb       = LW'(d0sq_r) << (TOP_POS - kb3_r);
    proda    = MW'(fa4_r) * DEPTH_M;
    prodb    = MW'(fb4_r) * DEPTH_M;
    la       = {ka6_r, ta6_r};
    lb       = {kb6_r, tb6_r};
    rnd      = {1'b0, p8_r} + ROUND_HALF;
    total    = TOTW'(rl_r) + TOTW'(loss9_r);
    neg      = TOTW'(0) - total;
  end

  always_ff @(posedge clk) begin
    // Stage 0: absolute differences.
    if (ce[0]) begin
      for (int a = 0; a < 3; a++) begin
        mag_r[a] <= mag_nxt[a];
      end
    end
    // Stage 1: squares.
    if (ce[1]) begin
      for (int a = 0; a < 3; a++) begin
        sq_r[a] <= SQW'(mag_r[a]) * SQW'(mag_r[a]);
      end
    end
    // Stage 2: squared distance.
    if (ce[2]) begin
      d2_r <= LW'(sq_r[0]) + LW'(sq_r[1]) + LW'(sq_r[2]);
    end
    // Stage 3: near-field test and leading-one positions.
    if (ce[3]) begin
      near_r[3] <= near_nxt;
      d2s3_r    <= d2_r;
      ka3_r     <= ka_nxt;
      kb3_r     <= kb_nxt;
    end
    // Stage 4: normalise and take the 32 bits below the leading one.
    if (ce[4]) begin
      near_r[4] <= near_r[3];
      fa4_r     <= ma[LW-2 -: 32];
      fb4_r     <= mb[LW-2 -: 32];
      ka4_r     <= ka3_r;
      kb4_r     <= kb3_r;
    end
    // Stage 5: table indices.
    if (ce[5]) begin
      near_r[5] <= near_r[4];
      ia5_r     <= proda[32 +: IW];
      ib5_r     <= prodb[32 +: IW];
      ka5_r     <= ka4_r;
      kb5_r     <= kb4_r;
    end
    // Stage 6: table read.
    if (ce[6]) begin
      near_r[6] <= near_r[5];
      ta6_r     <= log_rom[ia5_r];
      tb6_r     <= log_rom[ib5_r];
      ka6_r     <= ka5_r;
      kb6_r     <= kb5_r;
    end
    // Stage 7: log ratio, clamped at zero.
    if (ce[7]) begin
      near_r[7] <= near_r[6];
      l7_r      <= (la > lb) ? (la - lb) : '0;
    end
    // Stage 8: scale by exponent and log10(2).
    if (ce[8]) begin
      near_r[8] <= near_r[7];
      p8_r      <= PRW'(l7_r) * PRW'(coef_r);
    end
    // Stage 9: round half up into 1/256 dB.
    if (ce[9]) begin
      near_r[9] <= near_r[8];
      loss9_r   <= rnd[PRW:ROUND_SHIFT];
    end
    // Stage 10: zero for near field, else add reference loss, negate and saturate.
    if (ce[10]) begin
      near_r[10] <= near_r[9];
      if (near_r[9]) begin
        atten_r <= '0;
        sat_r   <= 1'b0;
      end else if (total > LIMIT_T) begin
        atten_r <= ATTEN_FLOOR;
        sat_r   <= 1'b1;
      end else begin
        atten_r <= neg[ATTEN_W-1:0];
        sat_r   <= 1'b0;
      end
    end
  end

  // Result channel.
  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {{(OUT_TDATA_W - ATTEN_W){1'b0}}, atten_r};

  always_comb begin
    out_tuser                = '0;
    out_tuser[USER_NEAR_BIT] = near_r[NST-1];
    out_tuser[USER_SAT_BIT]  = sat_r;
  end

endmodule

`default_nettype wire

/* rtl/ldpl_checker.sv */
`default_nettype none

`include "log_distance_path_loss_macros.svh"

// Checks on the result channel of the path loss block.
module ldpl_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [ldpl_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic [ldpl_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  import ldpl_pkg::*;

  logic [ATTEN_W-1:0] atten;
  logic               near;
  logic               sat;

  assign atten = out_tdata[ATTEN_W-1:0];
  assign near  = out_tuser[USER_NEAR_BIT];
  assign sat   = out_tuser[USER_SAT_BIT];

  // A near-field result is never also a clipped one.
  `LDPL_ASSERT_SAME(a_flags_exclusive, out_tvalid, !(near && sat))

  // A near-field result carries no attenuation.
  `LDPL_ASSERT_SAME(a_near_zero, out_tvalid && near, atten == {ATTEN_W{1'b0}})

  // A clipped result sits at the floor of the range.
  `LDPL_ASSERT_SAME(a_sat_floor, out_tvalid && sat, atten == ATTEN_FLOOR)

  // Attenuation is never positive.
  `LDPL_ASSERT_SAME(a_not_positive, out_tvalid, atten[ATTEN_W-1] || (atten == {ATTEN_W{1'b0}}))

  // A stalled result stays offered and unchanged.
  `LDPL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind log_distance_path_loss ldpl_checker u_ldpl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
